[rtl/core/dvf_pkg.sv]
`default_nettype none

package dvf_pkg;

  localparam int unsigned STORE_BYTES_DEF = 1048576;

  localparam int unsigned ADDR_W  = 28;
  localparam int unsigned ROWB_W  = 15;
  localparam int unsigned BLK_W   = 11;
  localparam int unsigned PIX_W   = 13;
  localparam int unsigned TOTAL_W = 21;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 21;

  localparam logic [CIDX_W-1:0] REG_FORMAT = 3'd0;
  localparam logic [CIDX_W-1:0] REG_FLIP   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_WIDTH  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_HEIGHT = 3'd3;
  localparam logic [CIDX_W-1:0] REG_TOTAL  = 3'd4;

  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;

  typedef struct packed {
    logic busy;
    logic hit;
    logic last;
    logic src_ok;
  } walk_stat_t;

  function automatic logic [BLK_W-1:0] blocks_of(input logic [PIX_W-1:0] pix);
    logic [BLK_W-1:0] b;
    b = pix[PIX_W-1:2];
    return (b == '0) ? BLK_W'(1) : b;
  endfunction

  function automatic logic [3:0] swizzle(input logic [3:0] k, input logic big);
    logic [3:0] s;
    s = k;
    if (big) begin
      if (k inside {[4'd0:4'd7]}) begin
        s = k ^ 4'd6;
      end else if (k inside {[4'd12:4'd15]}) begin
        s = k ^ 4'd3;
      end
    end else if (k inside {[4'd4:4'd7]}) begin
      s = k ^ 4'd3;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/core/dvf_store.sv]
`default_nettype none

module dvf_store #(
  parameter int unsigned DEPTH = dvf_pkg::STORE_BYTES_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/dvf_walk.sv]
`default_nettype none

module dvf_walk #(
  parameter int unsigned STORE_BYTES = dvf_pkg::STORE_BYTES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [dvf_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [dvf_pkg::CDATA_W-1:0]  cfg_data,
  input  wire logic                         step,
  output dvf_pkg::walk_stat_t               stat,
  output logic      [dvf_pkg::ADDR_W-1:0]   addr
);

  localparam int unsigned AW = dvf_pkg::ADDR_W;
  localparam int unsigned RW = dvf_pkg::ROWB_W;
  localparam int unsigned BW = dvf_pkg::BLK_W;
  localparam int unsigned TW = dvf_pkg::TOTAL_W;
  localparam logic [AW-1:0] STORE_LIM = AW'(STORE_BYTES);

  typedef enum logic [3:0] {
    W_INIT = 4'b0001,
    W_MUL  = 4'b0010,
    W_BASE = 4'b0100,
    W_RUN  = 4'b1000
  } walk_state_t;

  walk_state_t state_r, state_nxt;

  logic [1:0]                  fmt_r, fmt_nxt;
  logic                        flip_r, flip_nxt;
  logic [dvf_pkg::PIX_W-1:0]   wpix_r, wpix_nxt, hpix_r, hpix_nxt;
  logic [TW-1:0]               total_r, total_nxt;
  logic [TW-1:0]               rp_r, rp_nxt;
  logic [AW-1:0]               lvl_base_r, lvl_base_nxt;
  logic [AW-1:0]               srow_base_r, srow_base_nxt;
  logic [AW-1:0]               size_r, size_nxt;
  logic [BW-1:0]               wblk_r, wblk_nxt, hblk_r, hblk_nxt, row_r, row_nxt;
  logic [RW-1:0]               off_r, off_nxt;
  logic [2*BW-1:0]             prod_r, prod_nxt;

  logic          big;
  logic          flipping;
  logic          restart;
  logic [RW-1:0] rowb;
  logic [RW-1:0] off_inc;
  logic [3:0]    kk;
  logic [3:0]    swz;
  logic [RW-1:0] blk_part;
  logic [AW-1:0] src;
  logic [AW-1:0] len;
  logic [AW-1:0] rp_ext;
  logic [AW-1:0] size_calc;

  assign big      = (fmt_r == dvf_pkg::FMT_DXT3);
  assign flipping = flip_r && ((fmt_r == dvf_pkg::FMT_DXT1) || (fmt_r == dvf_pkg::FMT_DXT3));
  assign rowb     = big ? {wblk_r, 4'b0000} : {1'b0, wblk_r, 3'b000};
  assign off_inc  = off_r + RW'(1);
  assign kk       = big ? off_r[3:0] : {1'b0, off_r[2:0]};
  assign swz      = dvf_pkg::swizzle(kk, big);
  assign blk_part = big ? {off_r[RW-1:4], swz} : {off_r[RW-1:3], swz[2:0]};
  assign src      = srow_base_r + AW'(blk_part);
  assign size_calc = big ? AW'({prod_r, 4'b0000}) : AW'({prod_r, 3'b000});

  assign len    = (AW'(total_r) > STORE_LIM) ? STORE_LIM : AW'(total_r);
  assign rp_ext = AW'(rp_r);

  assign addr        = flipping ? src : rp_ext;
  assign stat.busy   = (state_r != W_RUN);
  assign stat.hit    = (rp_ext < len);
  assign stat.last   = ((rp_ext + AW'(1)) == len);
  assign stat.src_ok = !flipping || (src < STORE_LIM);

  always_comb begin
    state_nxt     = state_r;
    fmt_nxt       = fmt_r;
    flip_nxt      = flip_r;
    wpix_nxt      = wpix_r;
    hpix_nxt      = hpix_r;
    total_nxt     = total_r;
    rp_nxt        = rp_r;
    lvl_base_nxt  = lvl_base_r;
    srow_base_nxt = srow_base_r;
    size_nxt      = size_r;
    wblk_nxt      = wblk_r;
    hblk_nxt      = hblk_r;
    row_nxt       = row_r;
    off_nxt       = off_r;
    prod_nxt      = prod_r;
    restart       = 1'b0;

    case (state_r)
      W_INIT: begin
        wblk_nxt     = dvf_pkg::blocks_of(wpix_r);
        hblk_nxt     = dvf_pkg::blocks_of(hpix_r);
        rp_nxt       = '0;
        lvl_base_nxt = '0;
        row_nxt      = '0;
        off_nxt      = '0;
        state_nxt    = W_MUL;
      end
      W_MUL: begin
        prod_nxt  = wblk_r * hblk_r;
        state_nxt = W_BASE;
      end
      W_BASE: begin
        size_nxt      = size_calc;
        srow_base_nxt = lvl_base_r + size_calc - AW'(rowb);
        state_nxt     = W_RUN;
      end
      W_RUN: begin
        if (step) begin
          rp_nxt = rp_r + TW'(1);
          if (flipping) begin
            if (off_inc == rowb) begin
              off_nxt = '0;
              if ((row_r + BW'(1)) == hblk_r) begin
                lvl_base_nxt = lvl_base_r + size_r;
                row_nxt      = '0;
                wblk_nxt     = (wblk_r > BW'(1)) ? (wblk_r >> 1) : BW'(1);
                hblk_nxt     = (hblk_r > BW'(1)) ? (hblk_r >> 1) : BW'(1);
                state_nxt    = W_MUL;
              end else begin
                row_nxt       = row_r + BW'(1);
                srow_base_nxt = srow_base_r - AW'(rowb);
              end
            end else begin
              off_nxt = off_inc;
            end
          end
        end
      end
      default: begin
        state_nxt = W_INIT;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        dvf_pkg::REG_FORMAT: begin
          fmt_nxt = cfg_data[1:0];
          restart = 1'b1;
        end
        dvf_pkg::REG_FLIP: begin
          flip_nxt = cfg_data[0];
          restart  = 1'b1;
        end
        dvf_pkg::REG_WIDTH: begin
          wpix_nxt = cfg_data[dvf_pkg::PIX_W-1:0];
          restart  = 1'b1;
        end
        dvf_pkg::REG_HEIGHT: begin
          hpix_nxt = cfg_data[dvf_pkg::PIX_W-1:0];
          restart  = 1'b1;
        end
        dvf_pkg::REG_TOTAL: begin
          total_nxt = cfg_data[TW-1:0];
        end
        default: begin
        end
      endcase
    end

    if (restart) begin
      state_nxt = W_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_INIT;
      fmt_r   <= dvf_pkg::FMT_DXT1;
      flip_r  <= 1'b0;
      wpix_r  <= dvf_pkg::PIX_W'(4);
      hpix_r  <= dvf_pkg::PIX_W'(4);
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      fmt_r   <= fmt_nxt;
      flip_r  <= flip_nxt;
      wpix_r  <= wpix_nxt;
      hpix_r  <= hpix_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rp_r        <= rp_nxt;
    lvl_base_r  <= lvl_base_nxt;
    srow_base_r <= srow_base_nxt;
    size_r      <= size_nxt;
    wblk_r      <= wblk_nxt;
    hblk_r      <= hblk_nxt;
    row_r       <= row_nxt;
    off_r       <= off_nxt;
    prod_r      <= prod_nxt;
  end

endmodule

`default_nettype wire

[rtl/core/dxt_vertical_flip.sv]
// Channel   Ports                                   Direction
// in        in_valid in_stall in_func in_byte       load byte or drain request
// out       out_valid out_stall out_byte out_last   one byte per drain below total
// cfg       cfg_valid cfg_ready cfg_index cfg_data  register write, always ready
//
// A load writes one byte; a drain passes the store's read register, then out_byte_r.
// After reset and after each write of format, flip_enable, width_pixels or height_pixels
// the walk holds input in W_INIT, W_MUL, W_BASE; each new mip level in W_MUL, W_BASE.
// A result held by out_stall holds the input until it is taken.
`default_nettype none

module dxt_vertical_flip #(
  parameter int unsigned STORE_BYTES = dvf_pkg::STORE_BYTES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_func,
  input  wire logic [7:0]                   in_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [7:0]                   out_byte,
  output logic                              out_last,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [dvf_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [dvf_pkg::CDATA_W-1:0]  cfg_data
);

  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam int unsigned PW = $clog2(STORE_BYTES + 1);

  dvf_pkg::walk_stat_t           stat;
  logic [dvf_pkg::ADDR_W-1:0]    walk_addr;
  logic                          in_acc;
  logic                          step;
  logic                          load_we;
  logic [7:0]                    rdata;

  logic [PW-1:0] load_ptr_r, load_ptr_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          rd_last_r, rd_last_nxt;
  logic          rd_zero_r, rd_zero_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;

  assign cfg_ready = 1'b1;
  assign in_stall  = stat.busy | rd_pend_r | (out_valid_r & out_stall);
  assign in_acc    = in_valid & ~in_stall;
  assign step      = in_acc & in_func & stat.hit;
  assign load_we   = in_acc & ~in_func & (load_ptr_r < PW'(STORE_BYTES));

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  dvf_walk #(
    .STORE_BYTES(STORE_BYTES)
  ) u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .step     (step),
    .stat     (stat),
    .addr     (walk_addr)
  );

  dvf_store #(
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (load_we),
    .waddr(load_ptr_r[AW-1:0]),
    .wdata(in_byte),
    .re   (step),
    .raddr(walk_addr[AW-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    load_ptr_nxt  = load_ptr_r;
    rd_pend_nxt   = step;
    rd_last_nxt   = rd_last_r;
    rd_zero_nxt   = rd_zero_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (load_we) begin
      load_ptr_nxt = load_ptr_r + PW'(1);
    end
    if (step) begin
      rd_last_nxt = stat.last;
      rd_zero_nxt = ~stat.src_ok;
    end
    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = rd_zero_r ? 8'd0 : rdata;
      out_last_nxt  = rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_ptr_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      load_ptr_r  <= load_ptr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_last_r  <= rd_last_nxt;
    rd_zero_r  <= rd_zero_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire

[rtl/core/dvf_checker.sv]
`default_nettype none

module dvf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       in_func,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled item changed");

  a_rose_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_func, 2))
    else $error("item without drain");

  a_block_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while item held");

  a_gap_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("back to back items");

endmodule

bind dxt_vertical_flip dvf_checker u_dvf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_func  (in_func),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_byte (out_byte),
  .out_last (out_last)
);

`default_nettype wire
